@@ hw/rtl/tle_pkg.sv @@
// ----------------------------------------------------------------------------
// Terminal line editor package
// Shared constants, codes and the command and status records that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package tle_pkg;

  // Line store geometry.
  localparam int LINE_DEPTH = 16;
  localparam int LIMIT_CAP  = 16;
  localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CNT_W      = 5;
  localparam int LIMIT_W    = 5;

  // Largest effective limit.
  localparam logic [CNT_W-1:0] EFF_MAX =
    CNT_W'((LINE_DEPTH < LIMIT_CAP) ? LINE_DEPTH : LIMIT_CAP);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);

  // Register map: byte address bit 2 selects the register index.
  localparam int              PADDR_W         = 3;
  localparam logic            REG_LINE_LIMIT  = 1'b0;

  // Character codes.
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_BEL   = 8'd7;
  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_KILL  = 8'd24;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_DEL   = 8'd127;

  // Result kinds.
  localparam logic [1:0] KIND_ECHO   = 2'd0;
  localparam logic [1:0] KIND_LINE   = 2'd1;
  localparam logic [1:0] KIND_STATUS = 2'd2;

  // Line end status codes.
  localparam logic [1:0] END_EOL  = 2'd0;
  localparam logic [1:0] END_FULL = 2'd1;
  localparam logic [1:0] END_EOI  = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_BELL,
    S_ZERO,
    S_ERASE,
    S_ECHO_END,
    S_ECHO_FULL,
    S_LINE,
    S_STAT
  } state_t;

  // Class of the word on the input channel.
  typedef enum logic [2:0] {
    CLS_EOI,
    CLS_ERASE,
    CLS_EOL,
    CLS_KILL,
    CLS_CHAR
  } cls_t;

  // Character count operations.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_CLEAR,
    CNT_DEC,
    CNT_INC
  } cnt_op_t;

  // Source of the next result word.
  typedef enum logic [2:0] {
    OUT_BELL,
    OUT_ZERO,
    OUT_CHAR,
    OUT_ERASE,
    OUT_LINE,
    OUT_STAT
  } out_sel_t;

  typedef struct packed {
    logic     take;
    logic     store;
    cnt_op_t  cnt_op;
    logic     step_erase;
    logic     idx_inc;
    logic     out_load;
    out_sel_t out_sel;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    cls_t in_class;
    logic cnt_zero;
    logic full_hit;
    logic out_free;
    logic erase_last;
    logic line_done;
  } sts_t;

endpackage

@@ hw/rtl/tle_datapath.sv @@
// ----------------------------------------------------------------------------
// Terminal line editor datapath
// Line store, character count, walk counters and the output word register.
// ----------------------------------------------------------------------------
module tle_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [7:0]                  in_char,
  input  logic                        end_of_input,
  input  logic [tle_pkg::LIMIT_W-1:0] line_limit,
  input  tle_pkg::cmd_t               cmd,
  output tle_pkg::sts_t               sts,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  item_kind,
  output logic [7:0]                  out_byte,
  output logic [1:0]                  end_status,
  output logic                        last
);
  import tle_pkg::*;

  logic [7:0]       mem [LINE_DEPTH];
  logic [7:0]       rdata;
  logic [7:0]       ch;
  logic [1:0]       stat_code;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] new_count;
  logic [CNT_W-1:0] eff;
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] idx_next;
  logic [CNT_W-1:0] reps;
  logic [1:0]       phase;
  logic             wr_en;
  cls_t             in_class;
  logic [1:0]       kind_d;
  logic [7:0]       byte_d;
  logic [1:0]       stat_d;

  // Decode the incoming word.
  always_comb begin
    if (end_of_input) begin
      in_class = CLS_EOI;
    end else if (in_char inside {CH_BS, CH_DEL}) begin
      in_class = CLS_ERASE;
    end else if (in_char inside {CH_CR, CH_LF}) begin
      in_class = CLS_EOL;
    end else if (in_char == CH_KILL) begin
      in_class = CLS_KILL;
    end else begin
      in_class = CLS_CHAR;
    end
  end

  // Effective limit and the count after storing one more character.
  always_comb begin
    if (line_limit == '0) begin
      eff = CNT_W'(1);
    end else if (line_limit > EFF_MAX) begin
      eff = EFF_MAX;
    end else begin
      eff = line_limit;
    end
  end

  assign wr_en     = cmd.store && (count < CNT_W'(LINE_DEPTH));
  assign new_count = wr_en ? (count + CNT_W'(1)) : count;

  assign sts.in_class   = in_class;
  assign sts.cnt_zero   = (count == '0);
  assign sts.full_hit   = (in_class == CLS_CHAR) &&
                          (((count < CNT_W'(LINE_DEPTH)) ? (count + CNT_W'(1)) : count) >= eff);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.erase_last = (phase == 2'd2) && (reps == CNT_W'(1));
  assign sts.line_done  = (idx == len);

  // Character count.
  always_comb begin
    case (cmd.cnt_op)
      CNT_CLEAR: count_next = '0;
      CNT_DEC:   count_next = count - CNT_W'(1);
      CNT_INC:   count_next = new_count;
      default:   count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Line walk index; the read address follows its next value.
  always_comb begin
    if (cmd.take) begin
      idx_next = '0;
    end else if (cmd.idx_inc) begin
      idx_next = idx + CNT_W'(1);
    end else begin
      idx_next = idx;
    end
  end

  // Per-word latches, erase walk and line length.
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (cmd.take) begin
      ch    <= in_char;
      phase <= 2'd0;
      len   <= sts.full_hit ? (new_count - CNT_W'(1)) : count;
      reps  <= (in_class == CLS_KILL) ? count : CNT_W'(1);
      if (in_class == CLS_EOI) begin
        stat_code <= END_EOI;
      end else if (sts.full_hit) begin
        stat_code <= END_FULL;
      end else begin
        stat_code <= END_EOL;
      end
    end else if (cmd.step_erase) begin
      if (phase == 2'd2) begin
        phase <= 2'd0;
        reps  <= reps - CNT_W'(1);
      end else begin
        phase <= phase + 2'd1;
      end
    end
  end

  // Line store with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[ADDR_W-1:0]] <= in_char;
    end
    rdata <= mem[idx_next[ADDR_W-1:0]];
  end

  // Result word select.
  always_comb begin
    kind_d = KIND_ECHO;
    byte_d = CH_NUL;
    stat_d = END_EOL;
    case (cmd.out_sel)
      OUT_BELL:  byte_d = CH_BEL;
      OUT_ZERO:  byte_d = CH_NUL;
      OUT_CHAR:  byte_d = ch;
      OUT_ERASE: byte_d = (phase == 2'd1) ? CH_SPACE : CH_BS;
      OUT_LINE: begin
        kind_d = KIND_LINE;
        byte_d = rdata;
      end
      OUT_STAT: begin
        kind_d = KIND_STATUS;
        stat_d = stat_code;
      end
      default: byte_d = CH_NUL;
    endcase
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      item_kind  <= kind_d;
      out_byte   <= byte_d;
      end_status <= stat_d;
      last       <= cmd.out_last;
    end
  end

  // The count never reaches the largest effective limit between words.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < EFF_MAX)
    else $error("character count out of range");

  // The line walk never runs past the delivered length.
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.idx_inc |-> (idx < len))
    else $error("line walk past its length");

  // An erase step always has a repetition left.
  a_reps_left: assert property (@(posedge clk) disable iff (rst)
    cmd.step_erase |-> (reps != '0))
    else $error("erase step with no repetition left");

endmodule

@@ hw/rtl/tle_ctrl.sv @@
// ----------------------------------------------------------------------------
// Terminal line editor controller
// State machine that takes each input word and sequences its result words.
// ----------------------------------------------------------------------------
module tle_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  tle_pkg::sts_t sts,
  output tle_pkg::cmd_t cmd
);
  import tle_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    cmd.take       = 1'b0;
    cmd.store      = 1'b0;
    cmd.cnt_op     = CNT_HOLD;
    cmd.step_erase = 1'b0;
    cmd.idx_inc    = 1'b0;
    cmd.out_load   = 1'b0;
    cmd.out_sel    = OUT_ZERO;
    cmd.out_last   = 1'b0;
    in_stall       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          case (sts.in_class)
            CLS_EOI: begin
              cmd.cnt_op = CNT_CLEAR;
              state_next = S_STAT;
            end
            CLS_ERASE: begin
              if (sts.cnt_zero) begin
                state_next = S_BELL;
              end else begin
                cmd.cnt_op = CNT_DEC;
                state_next = S_ERASE;
              end
            end
            CLS_EOL: begin
              cmd.cnt_op = CNT_CLEAR;
              state_next = S_LINE;
            end
            CLS_KILL: begin
              if (sts.cnt_zero) begin
                state_next = S_ZERO;
              end else begin
                cmd.cnt_op = CNT_CLEAR;
                state_next = S_ERASE;
              end
            end
            default: begin
              cmd.store = 1'b1;
              if (sts.full_hit) begin
                cmd.cnt_op = CNT_CLEAR;
                state_next = S_ECHO_FULL;
              end else begin
                cmd.cnt_op = CNT_INC;
                state_next = S_ECHO_END;
              end
            end
          endcase
        end
      end
      S_BELL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_BELL;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ZERO: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_ZERO;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ERASE: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = OUT_ERASE;
          cmd.step_erase = 1'b1;
          cmd.out_last   = sts.erase_last;
          if (sts.erase_last) begin
            state_next = S_IDLE;
          end
        end
      end
      S_ECHO_END: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_CHAR;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_ECHO_FULL: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_CHAR;
          state_next   = S_LINE;
        end
      end
      S_LINE: begin
        if (sts.line_done) begin
          state_next = S_STAT;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_LINE;
          cmd.idx_inc  = 1'b1;
        end
      end
      S_STAT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = OUT_STAT;
          cmd.out_last = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // A word is only loaded into a free output register.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output word overwritten");

endmodule

@@ hw/rtl/terminal_line_editor.sv @@
// ----------------------------------------------------------------------------
// Terminal line editor
// Line editing with backspace, delete and kill, echo and line delivery.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake               Word
//   input    in         in_valid / in_stall     in_char, end_of_input
//   output   out        out_valid / out_stall   item_kind, out_byte,
//                                               end_status, last
//   config   in         APB psel/penable/pready line_limit at byte address 0
//
// An input word is accepted in S_IDLE and its result words are then loaded
// one after another; a delivered line also passes an end of line check.
// The single output word register takes one result a cycle while not stalled.
// Reset is synchronous and active high; the line is empty and line_limit is
// 16 afterwards. A stalled output holds the sequencer in place; the next
// input word is taken as soon as the last result is loaded.
// ----------------------------------------------------------------------------
module terminal_line_editor (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_char,
  input  logic                        end_of_input,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  item_kind,
  output logic [7:0]                  out_byte,
  output logic [1:0]                  end_status,
  output logic                        last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tle_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tle_pkg::*;

  logic [LIMIT_W-1:0] line_limit;
  logic               limit_sel;
  cmd_t               cmd;
  sts_t               sts;

  // Configuration register.
  assign pready    = 1'b1;
  assign limit_sel = (paddr[2] == REG_LINE_LIMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (psel && penable && pwrite && pready && limit_sel) begin
      line_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  assign prdata = limit_sel ? {{(32 - LIMIT_W){1'b0}}, line_limit} : 32'd0;

  tle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tle_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .line_limit   (line_limit),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .out_byte     (out_byte),
    .end_status   (end_status),
    .last         (last)
  );

endmodule

@@ verif/tb_terminal_line_editor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Terminal line editor testbench
// Sends single characters and end-of-input marks through the valid/stall
// input channel and checks every result word against a cycle-free predictor
// of the editor. Directed words cover the editing keys, empty-line cases,
// clamped limits and a limit lowered under a partly typed line; random lines
// follow under several line_limit settings and idling mixes.
// ----------------------------------------------------------------------------
module tb_terminal_line_editor;
  import tle_pkg::*;

  localparam int         CYCLE_LIMIT  = 600000;
  localparam int         WORDS_PER_PH = 50;
  localparam int         SETTLE       = 8;
  localparam logic [1:0] NO_STATUS    = 2'd0;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] status;
    logic       fin;
  } edit_result_t;

  // Predicts the result words of each accepted word and checks them in order.
  class line_edit_scoreboard;
    logic [7:0]   line_buf [LINE_DEPTH];
    int unsigned  chars;
    logic [4:0]   limit_reg;
    edit_result_t pending_results[$];
    edit_result_t burst[$];
    int           errors;

    function new();
      chars     = 0;
      limit_reg = LIMIT_RESET;
      errors    = 0;
    endfunction

    function void set_limit(logic [4:0] value);
      limit_reg = value;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Limit clamped into one to the largest supported line.
    function int unsigned eff_limit();
      int unsigned lim;
      lim = limit_reg;
      if (lim < 1) lim = 1;
      if (lim > EFF_MAX) lim = EFF_MAX;
      return lim;
    endfunction

    function void add(logic [1:0] kind, logic [7:0] data, logic [1:0] status);
      edit_result_t r;
      r.kind   = kind;
      r.data   = data;
      r.status = status;
      r.fin    = 1'b0;
      burst.push_back(r);
    endfunction

    function void add_erase();
      add(KIND_ECHO, CH_BS, NO_STATUS);
      add(KIND_ECHO, CH_SPACE, NO_STATUS);
      add(KIND_ECHO, CH_BS, NO_STATUS);
    endfunction

    function void deliver(int unsigned len, logic [1:0] status);
      for (int unsigned i = 0; i < len && i < LINE_DEPTH; i++) begin
        add(KIND_LINE, line_buf[i], NO_STATUS);
      end
      add(KIND_STATUS, CH_NUL, status);
      chars = 0;
    endfunction

    // Works out the result words of one accepted input word.
    function void note_word(logic [7:0] ch, logic eoi);
      burst.delete();
      if (eoi) begin
        chars = 0;
        add(KIND_STATUS, CH_NUL, END_EOI);
      end else if (ch == CH_BS || ch == CH_DEL) begin
        if (chars == 0) begin
          add(KIND_ECHO, CH_BEL, NO_STATUS);
        end else begin
          chars--;
          add_erase();
        end
      end else if (ch == CH_CR || ch == CH_LF) begin
        deliver(chars, END_EOL);
      end else if (ch == CH_KILL) begin
        for (int unsigned i = 0; i < chars && i < LIMIT_CAP; i++) begin
          add_erase();
        end
        chars = 0;
        // Killing an empty line still answers with one zero echo.
        if (burst.size() == 0) add(KIND_ECHO, CH_NUL, NO_STATUS);
      end else begin
        if (chars < LINE_DEPTH) begin
          line_buf[chars] = ch;
          chars++;
        end
        add(KIND_ECHO, ch, NO_STATUS);
        if (chars >= eff_limit()) deliver(chars - 1, END_FULL);
      end
      burst[burst.size() - 1].fin = 1'b1;
      foreach (burst[i]) pending_results.push_back(burst[i]);
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic [1:0] status,
                               logic fin);
      edit_result_t exp_r;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result word: kind=%0d byte=%02h status=%0d last=%0b",
                   kind, data, status, fin);
        return;
      end
      exp_r = pending_results.pop_front();
      if (kind !== exp_r.kind || data !== exp_r.data || status !== exp_r.status ||
          fin !== exp_r.fin) begin
        errors++;
        if (errors <= 10)
          $display("Result mismatch: expected kind=%0d byte=%02h status=%0d last=%0b, got kind=%0d byte=%02h status=%0d last=%0b",
                   exp_r.kind, exp_r.data, exp_r.status, exp_r.fin,
                   kind, data, status, fin);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_char;
  logic                 end_of_input;
  logic                 out_valid;
  logic                 out_stall;
  logic [1:0]           item_kind;
  logic [7:0]           out_byte;
  logic [1:0]           end_status;
  logic                 last;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;

  line_edit_scoreboard sb;
  int                  idle_pct;
  int                  stall_pct;
  int                  words_sent;
  int                  cycles;

  terminal_line_editor u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char      (in_char),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .item_kind    (item_kind),
    .out_byte     (out_byte),
    .end_status   (end_status),
    .last         (last),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog on the whole run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("FAIL terminal_line_editor");
        $finish;
      end
    end
  end

  // Output side: random stall, and a check of every accepted word.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall)
        sb.check_result(item_kind, out_byte, end_status, last);
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offers one word after a random gap and holds it until accepted.
  task automatic send_word(logic [7:0] ch, logic eoi);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char      <= ch;
    end_of_input <= eoi;
    do @(posedge clk); while (in_stall);
    sb.note_word(ch, eoi);
    words_sent++;
  endtask

  // Stops sending and waits until every predicted word has come out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write of line_limit; random upper data bits are ignored by the block.
  task automatic write_limit(logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({REG_LINE_LIMIT, 2'b00});
    pwdata  <= {27'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_limit(value);
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] ch;
    do begin
      ch = 8'($urandom_range(0, 255));
    end while (ch == CH_BS || ch == CH_DEL || ch == CH_CR || ch == CH_LF ||
               ch == CH_KILL);
    return ch;
  endfunction

  // One typed line with some corrections, then a random way of ending it.
  task automatic type_line();
    int len;
    int r;
    len = $urandom_range(0, 17);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) send_word($urandom_range(0, 1) ? CH_BS : CH_DEL, 1'b0);
      else if (r < 12) send_word(8'($urandom_range(0, 255)), 1'b0);
      else send_word(plain_char(), 1'b0);
    end
    r = $urandom_range(0, 99);
    if (r < 50) send_word($urandom_range(0, 1) ? CH_CR : CH_LF, 1'b0);
    else if (r < 65) send_word(CH_KILL, 1'b0);
    else if (r < 75) send_word(8'($urandom_range(0, 255)), 1'b1);
    else if (r < 80) send_word(CH_BS, 1'b0);
  endtask

  // Random lines under one setting until enough words have gone in.
  task automatic run_phase(logic [4:0] limit, int idle, int stall);
    int start;
    drain();
    write_limit(limit);
    idle_pct  = idle;
    stall_pct = stall;
    start     = words_sent;
    while (words_sent - start < WORDS_PER_PH) begin
      type_line();
      // Now and then hold the sender back until the output has caught up.
      if ($urandom_range(0, 7) == 0) drain();
    end
  endtask

  // Stimulus.
  initial begin
    sb           = new();
    idle_pct     = 0;
    stall_pct    = 0;
    words_sent   = 0;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    in_char      <= CH_NUL;
    end_of_input <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // End of input with a character that must be ignored, then the empty-line
    // cases of backspace, kill and carriage return.
    send_word(8'hFF, 1'b1);
    send_word(CH_BS, 1'b0);
    send_word(CH_KILL, 1'b0);
    send_word(CH_CR, 1'b0);

    // Extreme bytes stored, one deleted, the rest delivered by line feed.
    send_word(8'h41, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(CH_DEL, 1'b0);
    send_word(CH_LF, 1'b0);

    // Kill a line with two characters in it.
    send_word("X", 1'b0);
    send_word(" ", 1'b0);
    send_word(CH_KILL, 1'b0);

    // Lower the limit under a partly typed line, edit, then overflow it.
    send_word(8'h7E, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h55, 1'b0);
    send_word(8'h2A, 1'b0);
    drain();
    write_limit(5'd3);
    send_word(CH_BS, 1'b0);
    send_word("q", 1'b0);

    // A limit of one delivers an empty full line; zero is clamped up to one.
    drain();
    write_limit(5'd1);
    send_word("Z", 1'b0);
    drain();
    write_limit(5'd0);
    send_word(8'h00, 1'b1);
    send_word(8'h5A, 1'b0);

    // Random lines: no idling, idle sender, stalling receiver, both.
    run_phase(5'd31, 0, 0);
    run_phase(5'd6, 72, 0);
    run_phase(5'd2, 0, 72);
    run_phase(5'd16, 17, 17);

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS terminal_line_editor");
    end else begin
      $display("FAIL terminal_line_editor");
    end
    $finish;
  end

endmodule
